### design/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

  localparam int FRAME_W = 12;
  localparam int COUNT_W = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int MIN_FW  = 14;

  typedef enum logic [1:0] {
    CMD_INIT      = 2'd0,
    CMD_ALLOC_ONE = 2'd1,
    CMD_ALLOC_RUN = 2'd2,
    CMD_FREE_RUN  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_DOUBLE_FREE  = 3'd3,
    ST_ZERO_COUNT   = 3'd4
  } status_t;

  localparam logic [PADDR_W-1:0] REG_FRAMES_IN_USE = 3'd0;

endpackage

### design/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: command sequencer and bit/word datapath.
//
//   Channel   Signals                                Direction
//   request   in_valid/in_ready, cmd, frame, count   in
//   result    out_valid/out_ready, ok, alloc_frame,  out
//             status, free_total
//   config    psel/penable/pwrite/paddr/pwdata,      in/out
//             prdata, pready
//
// Init writes one bitmap word per cycle and then returns its result.
// Allocate one reads words in turn, each through S_LOAD, S_WAIT and S_ONE, until a free bit.
// Allocate run and free run walk one frame per cycle, pausing in S_LOAD and S_WAIT for each word loaded.
// A found run is walked again from its first frame to mark it; free run first skips one
// word per cycle up to its start frame.
// After reset a clearing pass marks every bitmap word as used before the first request.
// One request is handled at a time; a finished request waits while an untaken result is held.
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bfa_pkg::cmd_t                  cmd,
  input  logic [bfa_pkg::FRAME_W-1:0]    frame,
  input  logic [bfa_pkg::COUNT_W-1:0]    count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ok,
  output logic [bfa_pkg::FRAME_W-1:0]    alloc_frame,
  output bfa_pkg::status_t               status,
  output logic [bfa_pkg::COUNT_W-1:0]    free_total,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0]    paddr,
  input  logic [bfa_pkg::PDATA_W-1:0]    pwdata,
  output logic [bfa_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  import bfa_pkg::*;

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int FW = ($clog2(NUM_FRAMES + 1) > MIN_FW) ? $clog2(NUM_FRAMES + 1) : MIN_FW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT, S_SEEK, S_LOAD, S_WAIT, S_ONE, S_RUN, S_MARK, S_FREE, S_DONE
  } state_t;

  state_t                 state;
  cmd_t                   op;
  logic                   marking;
  logic [COUNT_W-1:0]     frames_in_use;
  logic [COUNT_W-1:0]     free_count;
  logic [COUNT_W-1:0]     cnt;
  logic [COUNT_W-1:0]     rem;
  logic [COUNT_W-1:0]     run;
  logic [FW-1:0]          fr;
  logic [FW-1:0]          tot;
  logic [FW-1:0]          f;
  logic [FW-1:0]          base;
  logic [AW-1:0]          widx;
  logic [BW-1:0]          boff;
  logic [FW-1:0]          first;
  logic [FW-1:0]          first_base;
  logic [AW-1:0]          first_widx;
  logic [BW-1:0]          first_boff;
  logic [WORD_BITS-1:0]   cur_word;
  logic                   ok_r;
  logic [FRAME_W-1:0]     start_r;
  status_t                status_r;

  logic [FW-1:0]          tot_c;
  logic [WORD_BITS-1:0]   rdata;
  logic                   we;
  logic [WORD_BITS-1:0]   wdata;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [WORD_BITS-1:0]   word_set;
  logic [WORD_BITS-1:0]   word_clr;
  logic [WORD_BITS-1:0]   init_word;
  logic [WORD_BITS-1:0]   one_word;
  logic [BW-1:0]          zero_pos;
  logic [FW-1:0]          fnd;
  logic                   any_free;
  logic                   at_end;
  logic                   last_word;
  logic                   cfg_we;
  logic [FW:0]            base_plus_wb;
  logic                   free_stop;
  status_t                free_code;

  function automatic logic [BW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BW-1:0] pos;
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        pos = BW'(b);
      end
    end
    return pos;
  endfunction

  bfa_map_mem #(
    .DEPTH(MAP_WORDS),
    .WIDTH(WORD_BITS),
    .AW   (AW)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(widx),
    .wdata(wdata),
    .raddr(widx),
    .rdata(rdata)
  );

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_FRAMES_IN_USE[PADDR_W-1]);
  assign prdata   = (paddr[PADDR_W-1] == REG_FRAMES_IN_USE[PADDR_W-1])
                    ? PDATA_W'(frames_in_use) : '0;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    tot_c = (FW'(frames_in_use) > FW'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : FW'(frames_in_use);
    bit_mask = WORD_BITS'(1) << boff;
    word_set = cur_word | bit_mask;
    word_clr = cur_word & ~bit_mask;
    zero_pos = lowest_zero(cur_word);
    one_word = cur_word | (WORD_BITS'(1) << zero_pos);
    fnd = base + FW'(zero_pos);
    any_free = (cur_word != '1);
    at_end = (boff == BW'(WORD_BITS - 1));
    last_word = (widx == AW'(MAP_WORDS - 1));
    base_plus_wb = {1'b0, base} + (FW + 1)'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      init_word[b] = !((({1'b0, base} + (FW + 1)'(b)) >= {1'b0, fr})
                       && (({1'b0, base} + (FW + 1)'(b)) < {1'b0, tot}));
    end
    free_stop = 1'b0;
    free_code = ST_OK;
    if (f != '0) begin
      if (f >= tot) begin
        free_stop = 1'b1;
        free_code = ST_OUT_OF_RANGE;
      end else if (!cur_word[boff]) begin
        free_stop = 1'b1;
        free_code = ST_DOUBLE_FREE;
      end
    end
    we = 1'b0;
    wdata = cur_word;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '1;
      end
      S_INIT: begin
        we = 1'b1;
        wdata = init_word;
      end
      S_ONE: begin
        we = any_free && (fnd < tot);
        wdata = one_word;
      end
      S_MARK: begin
        we = (rem == COUNT_W'(1)) || at_end;
        wdata = word_set;
      end
      S_FREE: begin
        we = free_stop || (rem == COUNT_W'(1)) || at_end;
        wdata = (free_stop || (f == '0)) ? cur_word : word_clr;
      end
      default: begin
        we = 1'b0;
        wdata = cur_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      widx          <= '0;
      free_count    <= '0;
      frames_in_use <= COUNT_W'(4096);
      out_valid     <= 1'b0;
      marking       <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= pwdata[COUNT_W-1:0];
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        ok          <= ok_r;
        alloc_frame <= start_r;
        status      <= status_r;
        free_total  <= free_count;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          widx <= widx + AW'(1);
          if (last_word) begin
            widx  <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op       <= cmd;
            cnt      <= count;
            rem      <= count;
            run      <= '0;
            fr       <= FW'(frame);
            tot      <= tot_c;
            widx     <= '0;
            base     <= '0;
            boff     <= '0;
            f        <= '0;
            marking  <= 1'b0;
            ok_r     <= 1'b1;
            start_r  <= '0;
            status_r <= ST_OK;
            unique case (cmd)
              CMD_INIT: begin
                free_count <= (tot_c > FW'(frame)) ? COUNT_W'(tot_c - FW'(frame)) : '0;
                state <= S_INIT;
              end
              CMD_ALLOC_ONE: begin
                if (free_count == '0) begin
                  ok_r     <= 1'b0;
                  status_r <= ST_NO_SPACE;
                  state    <= S_DONE;
                end else begin
                  state <= S_LOAD;
                end
              end
              CMD_ALLOC_RUN: begin
                if (count == '0) begin
                  ok_r     <= 1'b0;
                  status_r <= ST_ZERO_COUNT;
                  state    <= S_DONE;
                end else if (free_count < count) begin
                  ok_r     <= 1'b0;
                  status_r <= ST_NO_SPACE;
                  state    <= S_DONE;
                end else begin
                  state <= S_LOAD;
                end
              end
              CMD_FREE_RUN: begin
                f <= FW'(frame);
                state <= (count == '0) ? S_DONE : S_SEEK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_INIT: begin
          widx <= widx + AW'(1);
          base <= base + FW'(WORD_BITS);
          if (last_word) begin
            state <= S_DONE;
          end
        end
        S_SEEK: begin
          if ({1'b0, fr} >= base_plus_wb) begin
            base <= base + FW'(WORD_BITS);
            widx <= widx + AW'(1);
          end else begin
            boff  <= BW'(fr - base);
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (op == CMD_ALLOC_RUN && !marking && f >= tot) begin
            ok_r     <= 1'b0;
            status_r <= ST_NO_SPACE;
            state    <= S_DONE;
          end else if (op == CMD_FREE_RUN && f != '0 && f >= tot) begin
            ok_r     <= 1'b0;
            status_r <= ST_OUT_OF_RANGE;
            state    <= S_DONE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          cur_word <= rdata;
          priority if (op == CMD_ALLOC_ONE) begin
            state <= S_ONE;
          end else if (op == CMD_ALLOC_RUN) begin
            state <= marking ? S_MARK : S_RUN;
          end else begin
            state <= S_FREE;
          end
        end
        S_ONE: begin
          if (any_free) begin
            if (fnd < tot) begin
              free_count <= free_count - COUNT_W'(1);
              start_r    <= fnd[FRAME_W-1:0];
            end else begin
              ok_r     <= 1'b0;
              status_r <= ST_NO_SPACE;
            end
            state <= S_DONE;
          end else if (last_word) begin
            ok_r     <= 1'b0;
            status_r <= ST_NO_SPACE;
            state    <= S_DONE;
          end else begin
            widx  <= widx + AW'(1);
            base  <= base + FW'(WORD_BITS);
            state <= S_LOAD;
          end
        end
        S_RUN: begin
          if (f >= tot) begin
            ok_r     <= 1'b0;
            status_r <= ST_NO_SPACE;
            state    <= S_DONE;
          end else if (!cur_word[boff] && (run + COUNT_W'(1) == cnt)) begin
            marking <= 1'b1;
            rem     <= cnt;
            if (run == '0) begin
              first <= f;
            end else begin
              f     <= first;
              widx  <= first_widx;
              base  <= first_base;
              boff  <= first_boff;
            end
            state <= S_LOAD;
          end else begin
            if (cur_word[boff]) begin
              run <= '0;
            end else begin
              if (run == '0) begin
                first      <= f;
                first_widx <= widx;
                first_base <= base;
                first_boff <= boff;
              end
              run <= run + COUNT_W'(1);
            end
            f <= f + FW'(1);
            if (at_end) begin
              boff  <= '0;
              widx  <= widx + AW'(1);
              base  <= base + FW'(WORD_BITS);
              state <= S_LOAD;
            end else begin
              boff <= boff + BW'(1);
            end
          end
        end
        S_MARK: begin
          cur_word <= word_set;
          rem      <= rem - COUNT_W'(1);
          f        <= f + FW'(1);
          if (rem == COUNT_W'(1)) begin
            free_count <= free_count - cnt;
            start_r    <= first[FRAME_W-1:0];
            state      <= S_DONE;
          end else if (at_end) begin
            boff  <= '0;
            widx  <= widx + AW'(1);
            base  <= base + FW'(WORD_BITS);
            state <= S_LOAD;
          end else begin
            boff <= boff + BW'(1);
          end
        end
        S_FREE: begin
          if (free_stop) begin
            ok_r     <= 1'b0;
            status_r <= free_code;
            state    <= S_DONE;
          end else begin
            if (f != '0) begin
              cur_word   <= word_clr;
              free_count <= free_count + COUNT_W'(1);
            end
            rem <= rem - COUNT_W'(1);
            f   <= f + FW'(1);
            if (rem == COUNT_W'(1)) begin
              state <= S_DONE;
            end else if (at_end) begin
              boff  <= '0;
              widx  <= widx + AW'(1);
              base  <= base + FW'(WORD_BITS);
              state <= S_LOAD;
            end else begin
              boff <= boff + BW'(1);
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    FW'(free_count) <= FW'(NUM_FRAMES))
    else $error("free count exceeds the number of frames");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(alloc_frame)
                                   && $stable(status) && $stable(free_total)))
    else $error("pending result changed before it was taken");

  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_OK)))
    else $error("ok flag disagrees with status");

  a_empty_alloc_fails: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == CMD_ALLOC_ONE && free_count == '0)
    |=> (status_r == ST_NO_SPACE && state == S_DONE))
    else $error("allocation with no free frames did not fail");

endmodule

### design/bfa_map_mem.sv
// Used/free bitmap storage with one write port and one registered read port.
module bfa_map_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the bitmap frame allocator with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import bfa_pkg::*;

  localparam int NFRAMES = 4096;

  typedef struct packed {
    logic                ok;
    logic [FRAME_W-1:0]  alloc_frame;
    status_t             status;
    logic [COUNT_W-1:0]  free_total;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t cmd = CMD_INIT;
  logic [FRAME_W-1:0] frame = '0;
  logic [COUNT_W-1:0] count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok;
  logic [FRAME_W-1:0] alloc_frame;
  status_t status;
  logic [COUNT_W-1:0] free_total;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bit frame_used [NFRAMES];
  int unsigned free_tally;
  int unsigned managed_frames;
  alloc_result_t pending_results[$];
  int unsigned error_count;
  int unsigned request_count;
  int unsigned result_count;
  int unsigned idle_cycles;
  bit stall_enable;

  bitmap_frame_allocator u_top (.*);

  always #5 clk = ~clk;

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic alloc_result_t predict_allocation(cmd_t c, int unsigned f0,
                                                       int unsigned n);
    alloc_result_t res;
    int unsigned tot, run, first, f;
    bit found;
    tot = (managed_frames > NFRAMES) ? NFRAMES : managed_frames;
    res.ok = 1'b1;
    res.alloc_frame = '0;
    res.status = ST_OK;
    found = 1'b0;
    case (c)
      CMD_INIT: begin
        free_tally = 0;
        for (int i = 0; i < NFRAMES; i++) begin
          frame_used[i] = !(i >= f0 && i < tot);
          if (!frame_used[i]) free_tally++;
        end
      end
      CMD_ALLOC_ONE: begin
        f = 0;
        if (free_tally != 0) begin
          for (f = 0; f < NFRAMES; f++) begin
            if (!frame_used[f]) begin
              found = f < tot;
              break;
            end
          end
        end
        if (found) begin
          frame_used[f] = 1'b1;
          free_tally--;
          res.alloc_frame = f[FRAME_W-1:0];
        end else begin
          res.ok = 1'b0;
          res.status = ST_NO_SPACE;
        end
      end
      CMD_ALLOC_RUN: begin
        if (n == 0) begin
          res.ok = 1'b0;
          res.status = ST_ZERO_COUNT;
        end else if (free_tally < n) begin
          res.ok = 1'b0;
          res.status = ST_NO_SPACE;
        end else begin
          run = 0;
          first = 0;
          for (f = 0; f < tot; f++) begin
            if (frame_used[f]) begin
              run = 0;
            end else begin
              if (run == 0) first = f;
              run++;
              if (run == n) begin
                found = 1'b1;
                break;
              end
            end
          end
          if (found) begin
            for (int i = 0; i < n; i++) frame_used[first + i] = 1'b1;
            free_tally -= n;
            res.alloc_frame = first[FRAME_W-1:0];
          end else begin
            res.ok = 1'b0;
            res.status = ST_NO_SPACE;
          end
        end
      end
      default: begin
        for (int i = 0; i < n; i++) begin
          f = f0 + i;
          if (f == 0) continue;
          if (f >= tot) begin
            res.ok = 1'b0;
            res.status = ST_OUT_OF_RANGE;
            break;
          end
          if (!frame_used[f]) begin
            res.ok = 1'b0;
            res.status = ST_DOUBLE_FREE;
            break;
          end
          frame_used[f] = 1'b0;
          free_tally++;
        end
      end
    endcase
    res.free_total = (free_tally > 8191) ? 13'h1FFF : free_tally[COUNT_W-1:0];
    return res;
  endfunction

  task automatic send_request(cmd_t c, int unsigned f0, int unsigned n);
    int unsigned gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    frame <= f0[FRAME_W-1:0];
    count <= n[COUNT_W-1:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_allocation(c, f0 & 12'hFFF, n & 13'h1FFF));
    request_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_frames_in_use(int unsigned value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_FRAMES_IN_USE;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    managed_frames = value & 32'h1FFF;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0d start=%0d status=%0d free=%0d",
                 $time, ok, alloc_frame, status, free_total);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (ok !== exp_res.ok || alloc_frame !== exp_res.alloc_frame ||
            status !== exp_res.status || free_total !== exp_res.free_total) begin
          $display("%0t: mismatch expected ok=%0d start=%0d status=%0d free=%0d",
                   $time, exp_res.ok, exp_res.alloc_frame, exp_res.status,
                   exp_res.free_total);
          $display("%0t:          actual   ok=%0d start=%0d status=%0d free=%0d",
                   $time, ok, alloc_frame, status, free_total);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!stall_enable || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 60000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_directed_edges();
    send_request(CMD_ALLOC_ONE, 0, 0);
    send_request(CMD_INIT, 1, 0);
    send_request(CMD_ALLOC_ONE, 0, 0);
    send_request(CMD_ALLOC_RUN, 0, 0);
    send_request(CMD_ALLOC_RUN, 0, 4096);
    send_request(CMD_ALLOC_RUN, 0, 8191);
    send_request(CMD_ALLOC_RUN, 0, 100);
    send_request(CMD_FREE_RUN, 0, 5);
    send_request(CMD_FREE_RUN, 2, 3);
    send_request(CMD_FREE_RUN, 3, 0);
    send_request(CMD_FREE_RUN, 4090, 20);
    send_request(CMD_ALLOC_RUN, 0, 4094);
    send_request(CMD_ALLOC_ONE, 0, 0);
    send_request(CMD_FREE_RUN, 4095, 1);
    send_request(CMD_INIT, 4095, 0);
    send_request(CMD_ALLOC_RUN, 0, 1);
    send_request(CMD_INIT, 0, 0);
    send_request(CMD_ALLOC_ONE, 0, 0);
  endtask

  task automatic test_frame_total();
    write_frames_in_use(0);
    send_request(CMD_INIT, 0, 0);
    send_request(CMD_ALLOC_ONE, 0, 0);
    send_request(CMD_ALLOC_RUN, 0, 1);
    send_request(CMD_FREE_RUN, 0, 3);
    write_frames_in_use(64);
    send_request(CMD_INIT, 100, 0);
    send_request(CMD_INIT, 10, 0);
    write_frames_in_use(8);
    send_request(CMD_ALLOC_ONE, 0, 0);
    send_request(CMD_ALLOC_RUN, 0, 2);
    write_frames_in_use(8191);
    send_request(CMD_INIT, 4000, 0);
    send_request(CMD_ALLOC_RUN, 0, 96);
    write_frames_in_use(1);
    send_request(CMD_INIT, 0, 0);
    send_request(CMD_ALLOC_ONE, 0, 0);
  endtask

  task automatic test_random_traffic(int unsigned total, int unsigned size);
    int unsigned r, base;
    write_frames_in_use(size);
    send_request(CMD_INIT, $urandom_range(0, 3), 0);
    for (int i = 0; i < total; i++) begin
      r = $urandom_range(0, 99);
      base = $urandom_range(0, size + 4);
      if (r < 3) begin
        send_request(CMD_INIT, $urandom_range(0, 4095) & ($urandom_range(0, 1) ? 12'hFFF :
                     12'h03F), 0);
      end else if (r < 35) begin
        send_request(CMD_ALLOC_ONE, $urandom, $urandom);
      end else if (r < 65) begin
        send_request(CMD_ALLOC_RUN, $urandom,
                     ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12));
      end else begin
        send_request(CMD_FREE_RUN, ($urandom_range(0, 9) == 0) ? $urandom : base,
                     ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 10));
      end
    end
  endtask

  initial begin
    error_count = 0;
    request_count = 0;
    result_count = 0;
    managed_frames = 4096;
    free_tally = 0;
    for (int i = 0; i < NFRAMES; i++) frame_used[i] = 1'b1;
    stall_enable = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_frame_total();
    stall_enable = 1'b1;
    test_random_traffic(150, 96);
    test_random_traffic(100, 200);
    stall_enable = 1'b0;
    test_random_traffic(100, 4096);
    stall_enable = 1'b1;
    test_random_traffic(100, 130);
    wait_drained();
    $display("Ran %0d requests over frame totals 0 to 8191, %0d results checked.",
             request_count, result_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
design/bfa_pkg.sv
design/bfa_map_mem.sv
design/bitmap_frame_allocator.sv
dv/testbench.sv
